@@ rtl/pli_pkg.sv @@
// Package for the piecewise linear interpolator.
// Holds shared constants, register indexes and the sequencer state type.
package pli_pkg;
    localparam int KnotDepthDefault = 64;
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_KNOT_COUNT = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_FAIL_MODE = 1'b1;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ENDS,
        S_CHK_ENDS,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MUL,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;
endpackage

@@ rtl/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator over a table of knots held in two synchronous
// memories, one for x and one for y, each with a registered read port. A query
// first reads the first and last knot, then scans segments one knot at a time
// from the start of the table, then multiplies once and runs a 64-bit restoring
// divider at one quotient bit per cycle. The table needs no clearing after reset.
// A query below the first knot or above the last one ends without a scan.
// Depends on pli_pkg.
module piecewise_linear_interpolator #(
    parameter int KNOT_DEPTH = pli_pkg::KnotDepthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [5:0]                  i_knot_index,
    input  logic signed [31:0]          i_x_value,
    input  logic signed [31:0]          i_y_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_y_result,
    output logic                        o_not_a_number,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pli_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import pli_pkg::*;

    localparam int AW = (KNOT_DEPTH > 1) ? $clog2(KNOT_DEPTH) : 1;
    localparam int CW = AW + 1;

    t_state r_state, n_state;

    logic [31:0] r_mem_x [KNOT_DEPTH];
    logic [31:0] r_mem_y [KNOT_DEPTH];
    logic [31:0] r_rd_x, r_rd_y;
    logic [AW-1:0] rd_addr;
    logic rd_en;

    logic [6:0] r_knot_count;
    logic r_fail_mode;
    logic signed [31:0] r_q;
    logic signed [31:0] r_xa, r_ya, r_x0;
    logic [AW-1:0] r_j, n_j;
    logic [CW-1:0] n_eff;
    logic [AW-1:0] last_idx;
    logic signed [32:0] r_dy;
    logic [32:0] r_den, r_off;
    logic [63:0] r_num, r_quo;
    logic [32:0] r_rem;
    logic [6:0] r_bit;
    logic signed [31:0] r_out_y;
    logic r_out_nan, r_out_v;
    logic found_ok, at_last, in_rng;
    logic [33:0] rem_sh;
    logic signed [34:0] sum_w;

    always_comb begin
        if (r_knot_count < 7'd2) begin
            n_eff = CW'(2);
        end else if (32'(r_knot_count) > 32'(KNOT_DEPTH)) begin
            n_eff = CW'(KNOT_DEPTH);
        end else begin
            n_eff = CW'(r_knot_count);
        end
        last_idx = AW'(n_eff - CW'(1));
    end

    assign o_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_out_v;
    assign o_y_result = r_out_y;
    assign o_not_a_number = r_out_nan;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_op == OP_WRITE && 32'(i_knot_index) < 32'(KNOT_DEPTH)) begin
            r_mem_x[AW'(i_knot_index)] <= i_x_value;
            r_mem_y[AW'(i_knot_index)] <= i_y_value;
        end
        if (rd_en) begin
            r_rd_x <= r_mem_x[rd_addr];
            r_rd_y <= r_mem_y[rd_addr];
        end
    end

    // Read address per state: ends are read as x[0] then x[last] in turn.
    always_comb begin
        rd_en = 1'b0;
        rd_addr = r_j;
        unique case (r_state)
            S_RD_ENDS: begin
                rd_en = 1'b1;
                rd_addr = r_j;
            end
            S_SCAN_RD: begin
                rd_en = 1'b1;
                rd_addr = r_j;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign in_rng = ($signed(r_rd_x) >= r_q);
    assign at_last = (r_j == last_idx);
    assign found_ok = ($signed(r_rd_x) >= r_q);
    assign rem_sh = {r_rem, r_num[63]};
    assign sum_w = 35'(r_ya) + ((r_dy < 0) ? -$signed({2'b0, r_quo[32:0]})
                                          : $signed({2'b0, r_quo[32:0]}));

    // Scan phases: x_lo is compared on entry, then x_last, then segments.
    logic r_phase;

    always_comb begin
        n_state = r_state;
        n_j = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready && i_op == OP_QUERY) begin
                    n_state = S_RD_ENDS;
                    n_j = '0;
                end
            end
            S_RD_ENDS: n_state = S_CHK_ENDS;
            S_CHK_ENDS: begin
                if (!r_phase) begin
                    if ($signed(r_rd_x) > r_q) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD_ENDS;
                        n_j = last_idx;
                    end
                end else if (!in_rng) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN_RD;
                    n_j = AW'(1);
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (found_ok) begin
                    n_state = ($signed(r_xa) == r_q) ? S_OUT : S_MUL;
                end else if (at_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN_RD;
                    n_j = r_j + AW'(1);
                end
            end
            S_MUL: n_state = (r_den == '0) ? S_OUT : S_DIV;
            S_DIV: n_state = (r_bit == 7'd0) ? S_SUM : S_DIV;
            S_SUM: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_knot_count <= 7'd2;
            r_fail_mode <= 1'b1;
            r_out_v <= 1'b0;
            r_phase <= 1'b0;
            r_j <= '0;
        end else begin
            r_state <= n_state;
            r_j <= n_j;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KNOT_COUNT: r_knot_count <= i_cfg_data[6:0];
                    CFG_FAIL_MODE: r_fail_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_phase <= 1'b0;
            end else if (r_state == S_CHK_ENDS) begin
                r_phase <= 1'b1;
            end
            if (r_state == S_OUT) begin
                r_out_v <= 1'b1;
            end
        end
    end

    // Datapath registers; the result defaults to out of range until found.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready && i_op == OP_QUERY) begin
                    r_q <= i_x_value;
                    r_out_y <= '0;
                    r_out_nan <= r_fail_mode;
                end
            end
            S_CHK_ENDS: begin
                if (!r_phase) begin
                    r_xa <= r_rd_x;
                    r_ya <= r_rd_y;
                end
            end
            S_SCAN_CHK: begin
                if (found_ok) begin
                    if ($signed(r_xa) == r_q) begin
                        r_out_y <= r_ya;
                        r_out_nan <= 1'b0;
                    end else begin
                        r_dy <= 33'($signed(r_rd_y)) - 33'(r_ya);
                        r_off <= 33'(r_q) - 33'(r_xa);
                        r_den <= 33'($signed(r_rd_x)) - 33'(r_xa);
                        r_x0 <= r_ya;
                    end
                end else begin
                    r_xa <= r_rd_x;
                    r_ya <= r_rd_y;
                end
            end
            S_MUL: begin
                r_num <= 64'((r_dy < 0) ? 33'(-r_dy) : 33'(r_dy)) * 64'(r_off);
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= 7'd63;
                if (r_den == '0) begin
                    r_out_y <= r_x0;
                    r_out_nan <= 1'b0;
                end
            end
            S_DIV: begin
                r_num <= {r_num[62:0], 1'b0};
                r_bit <= r_bit - 7'd1;
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= 33'(rem_sh - {1'b0, r_den});
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[32:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
            end
            S_SUM: begin
                r_out_nan <= 1'b0;
                if (r_quo[63:33] != '0) begin
                    r_out_y <= (r_dy < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else if (sum_w > 35'sd2147483647) begin
                    r_out_y <= 32'sh7FFF_FFFF;
                end else if (sum_w < -35'sd2147483648) begin
                    r_out_y <= 32'sh8000_0000;
                end else begin
                    r_out_y <= sum_w[31:0];
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input accepted while a query is in progress");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_y_result)))
        else $error("pending result changed before it was taken");
    a_nan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_not_a_number) |-> (o_y_result == '0))
        else $error("not-a-number result carries a nonzero value");
`endif
endmodule
